// ----- src/i2cram_pkg.sv -----
// shared types and constants for the i2c register access master
package i2cram_pkg;

    localparam int DEV_ADDR_W = 7;
    localparam int REG_ADDR_W = 16;
    localparam int COUNT_W    = 5;
    localparam int BYTE_W     = 8;
    localparam int FUNC_W     = 2;
    // byte index runs over three header bytes, the read address and up to 31 data bytes
    localparam int BIDX_W     = 6;
    localparam int HDR_BYTES  = 3;

    localparam logic [DEV_ADDR_W-1:0] DEV_ADDR_RESET = 7'd20;

    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd2;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_START,
        CMD_LOAD,
        CMD_NOP
    } cmd_kind_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_WBIT,
        PH_WACK,
        PH_RBIT,
        PH_RACK,
        PH_STOP
    } phase_t;

    typedef struct packed {
        cmd_kind_t              cmd;
        logic                   sda_in;
        logic                   is_read;
        logic [REG_ADDR_W-1:0]  reg_address;
        logic [COUNT_W-1:0]     count;
        logic [BYTE_W-1:0]      write_byte;
    } item_t;

    typedef struct packed {
        logic                   scl;
        logic                   sda_out;
        logic [BYTE_W-1:0]      read_byte;
        logic                   read_valid;
        logic                   busy_res;
        logic                   done_res;
        logic                   nack_error;
    } result_t;

endpackage

// ----- src/i2cram_ram.sv -----
// generic single write port ram with registered read
module i2cram_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ----- src/i2cram_fifo.sv -----
// small register queue, used on both sides of the execution stage
module i2cram_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- src/i2cram_front.sv -----
// input side: accepts beats, decodes the function code and clamps the byte count
module i2cram_front #(
    parameter int MAX_BYTES = 16
) (
    input  logic                               push,
    input  logic                               q_full,
    input  logic [i2cram_pkg::FUNC_W-1:0]      func,
    input  logic                               sda_in,
    input  logic                               is_read,
    input  logic [i2cram_pkg::REG_ADDR_W-1:0]  reg_address,
    input  logic [i2cram_pkg::COUNT_W-1:0]     byte_count,
    input  logic [i2cram_pkg::BYTE_W-1:0]      write_byte,
    output logic                               q_push,
    output i2cram_pkg::item_t                  q_item
);

    import i2cram_pkg::*;

    cmd_kind_t          cmd;
    logic [COUNT_W-1:0] count_sat;

    always_comb
    begin
        unique case (func)
            FUNC_TICK:  cmd = CMD_TICK;
            FUNC_START: cmd = CMD_START;
            FUNC_LOAD:  cmd = CMD_LOAD;
            default:    cmd = CMD_NOP;
        endcase
    end

    always_comb
    begin
        if (int'(byte_count) > MAX_BYTES)
        begin
            count_sat = COUNT_W'(MAX_BYTES);
        end
        else
        begin
            count_sat = byte_count;
        end
    end

    assign q_push             = push && !q_full;
    assign q_item.cmd         = cmd;
    assign q_item.sda_in      = sda_in;
    assign q_item.is_read     = is_read;
    assign q_item.reg_address = reg_address;
    assign q_item.count       = count_sat;
    assign q_item.write_byte  = write_byte;

endmodule

// ----- src/i2cram_back.sv -----
// execution side: bus sequencer, write buffer and device address register
module i2cram_back #(
    parameter int MAX_BYTES = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr,
    input  logic [i2cram_pkg::DEV_ADDR_W-1:0]  cfg_data,
    input  i2cram_pkg::item_t                  item,
    input  logic                               in_empty,
    output logic                               in_pop,
    input  logic                               out_full,
    output logic                               out_push,
    output i2cram_pkg::result_t                res
);

    import i2cram_pkg::*;

    localparam int FILL_W = $clog2(MAX_BYTES + 1);
    localparam int ADDR_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

    phase_t                 phase_reg, phase_next;
    logic [1:0]             tick_reg, tick_next;
    logic [2:0]             bit_cnt_reg, bit_cnt_next;
    logic [BYTE_W-1:0]      shift_reg, shift_next;
    logic [BIDX_W-1:0]      byte_idx_reg, byte_idx_next;
    logic [REG_ADDR_W-1:0]  addr_reg, addr_next;
    logic                   dir_reg, dir_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic                   nack_reg, nack_next;
    logic                   line_scl_reg, line_scl_next;
    logic                   line_sda_reg, line_sda_next;
    logic [DEV_ADDR_W-1:0]  dev_addr_reg;

    logic                   fire;
    logic                   last;
    logic [BIDX_W-1:0]      idx_inc;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [BYTE_W-1:0]      ram_rdata;
    result_t                res_d;

    function automatic logic [BYTE_W-1:0] header_byte(
        input logic [BIDX_W-1:0]     idx,
        input logic [DEV_ADDR_W-1:0] dev,
        input logic [REG_ADDR_W-1:0] addr
    );
        logic [BYTE_W-1:0] b;
        if (idx == '0)
        begin
            b = {dev, 1'b0};
        end
        else if (idx == BIDX_W'(1))
        begin
            b = addr[15:8];
        end
        else if (idx == BIDX_W'(2))
        begin
            b = addr[7:0];
        end
        else
        begin
            b = {dev, 1'b1};
        end
        return b;
    endfunction

    // the next data byte sits at byte index + 1 - 3; the read data is registered,
    // and the index never moves in the beat just before it is consumed
    assign ram_raddr = ADDR_W'(byte_idx_reg - BIDX_W'(2));

    i2cram_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_BYTES)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(fill_reg)),
        .wdata (item.write_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign fire     = !in_empty && !out_full;
    assign in_pop   = fire;
    assign out_push = fire;
    assign res      = res_d;
    assign idx_inc  = byte_idx_reg + 1'b1;

    always_comb
    begin
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        bit_cnt_next  = bit_cnt_reg;
        shift_next    = shift_reg;
        byte_idx_next = byte_idx_reg;
        addr_next     = addr_reg;
        dir_next      = dir_reg;
        count_next    = count_reg;
        fill_next     = fill_reg;
        nack_next     = nack_reg;
        line_scl_next = line_scl_reg;
        line_sda_next = line_sda_reg;
        ram_we        = 1'b0;
        last          = 1'b0;
        res_d         = '0;
        res_d.scl     = line_scl_reg;
        res_d.sda_out = line_sda_reg;

        if (fire)
        begin
            unique case (item.cmd)
                CMD_START:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        dir_next      = item.is_read;
                        addr_next     = item.reg_address;
                        count_next    = item.count;
                        byte_idx_next = '0;
                        nack_next     = 1'b0;
                        tick_next     = '0;
                        phase_next    = PH_START;
                    end
                end
                CMD_LOAD:
                begin
                    if (phase_reg == PH_IDLE && fill_reg < FILL_W'(MAX_BYTES))
                    begin
                        ram_we    = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                end
                CMD_TICK:
                begin
                    unique case (phase_reg)
                        PH_IDLE:
                        begin
                            res_d.scl     = 1'b1;
                            res_d.sda_out = 1'b1;
                        end
                        PH_START:
                        begin
                            res_d.scl     = (tick_reg < 2'd2);
                            res_d.sda_out = (tick_reg == 2'd0);
                            if (tick_reg >= 2'd2)
                            begin
                                last         = 1'b1;
                                shift_next   = header_byte(byte_idx_reg, dev_addr_reg, addr_reg);
                                bit_cnt_next = '0;
                                phase_next   = PH_WBIT;
                            end
                        end
                        PH_WBIT:
                        begin
                            res_d.scl     = (tick_reg >= 2'd2);
                            res_d.sda_out = shift_reg[BYTE_W-1];
                            if (tick_reg >= 2'd2)
                            begin
                                last       = 1'b1;
                                shift_next = {shift_reg[BYTE_W-2:0], 1'b0};
                                bit_cnt_next = bit_cnt_reg + 1'b1;
                                if (bit_cnt_reg == 3'd7)
                                begin
                                    phase_next = PH_WACK;
                                end
                            end
                        end
                        PH_WACK:
                        begin
                            res_d.scl     = (tick_reg == 2'd1);
                            res_d.sda_out = 1'b1;
                            if (tick_reg == 2'd1)
                            begin
                                nack_next = item.sda_in;
                            end
                            if (tick_reg >= 2'd2)
                            begin
                                last = 1'b1;
                                if (nack_reg)
                                begin
                                    phase_next = PH_STOP;
                                end
                                else
                                begin
                                    byte_idx_next = idx_inc;
                                    if (idx_inc < BIDX_W'(HDR_BYTES))
                                    begin
                                        shift_next = header_byte(idx_inc, dev_addr_reg, addr_reg);
                                        bit_cnt_next = '0;
                                        phase_next   = PH_WBIT;
                                    end
                                    else if (!dir_reg)
                                    begin
                                        if ((idx_inc - BIDX_W'(HDR_BYTES)) < BIDX_W'(count_reg))
                                        begin
                                            shift_next   = ram_rdata;
                                            bit_cnt_next = '0;
                                            phase_next   = PH_WBIT;
                                        end
                                        else
                                        begin
                                            phase_next = PH_STOP;
                                        end
                                    end
                                    else if (idx_inc == BIDX_W'(HDR_BYTES))
                                    begin
                                        // repeated start before the read address
                                        phase_next = PH_START;
                                    end
                                    else if (count_reg != '0)
                                    begin
                                        shift_next   = '0;
                                        bit_cnt_next = '0;
                                        phase_next   = PH_RBIT;
                                    end
                                    else
                                    begin
                                        phase_next = PH_STOP;
                                    end
                                end
                            end
                        end
                        PH_RBIT:
                        begin
                            res_d.scl     = (tick_reg >= 2'd1);
                            res_d.sda_out = 1'b1;
                            if (tick_reg >= 2'd1)
                            begin
                                last         = 1'b1;
                                shift_next   = {shift_reg[BYTE_W-2:0], item.sda_in};
                                bit_cnt_next = bit_cnt_reg + 1'b1;
                                if (bit_cnt_reg == 3'd7)
                                begin
                                    res_d.read_valid = 1'b1;
                                    res_d.read_byte  = shift_next;
                                    phase_next       = PH_RACK;
                                end
                            end
                        end
                        PH_RACK:
                        begin
                            res_d.scl = (tick_reg == 2'd1);
                            // nack on the last byte, ack on the others
                            res_d.sda_out = ((byte_idx_reg - BIDX_W'(HDR_BYTES))
                                             >= BIDX_W'(count_reg));
                            if (tick_reg >= 2'd2)
                            begin
                                last          = 1'b1;
                                byte_idx_next = idx_inc;
                                if (!res_d.sda_out)
                                begin
                                    shift_next   = '0;
                                    bit_cnt_next = '0;
                                    phase_next   = PH_RBIT;
                                end
                                else
                                begin
                                    phase_next = PH_STOP;
                                end
                            end
                        end
                        PH_STOP:
                        begin
                            res_d.scl     = (tick_reg >= 2'd1);
                            res_d.sda_out = (tick_reg >= 2'd2);
                            if (tick_reg >= 2'd2)
                            begin
                                last             = 1'b1;
                                res_d.done_res   = 1'b1;
                                res_d.nack_error = nack_reg;
                                nack_next        = 1'b0;
                                fill_next        = '0;
                                phase_next       = PH_IDLE;
                            end
                        end
                        default:
                        begin
                            phase_next    = PH_IDLE;
                            res_d.scl     = 1'b1;
                            res_d.sda_out = 1'b1;
                        end
                    endcase
                    if (phase_reg != PH_IDLE)
                    begin
                        tick_next = last ? 2'd0 : tick_reg + 1'b1;
                    end
                    line_scl_next = res_d.scl;
                    line_sda_next = res_d.sda_out;
                end
                CMD_NOP:
                begin
                end
                default:
                begin
                end
            endcase
        end

        // a tick reports the phase it ran in, so the stop beat still shows busy
        if (item.cmd == CMD_TICK)
        begin
            res_d.busy_res = (phase_reg != PH_IDLE);
        end
        else
        begin
            res_d.busy_res = (phase_next != PH_IDLE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg     <= '0;
            bit_cnt_reg  <= '0;
            shift_reg    <= '0;
            byte_idx_reg <= '0;
            addr_reg     <= '0;
            dir_reg      <= 1'b0;
            count_reg    <= '0;
            fill_reg     <= '0;
            nack_reg     <= 1'b0;
            line_scl_reg <= 1'b1;
            line_sda_reg <= 1'b1;
            dev_addr_reg <= DEV_ADDR_RESET;
        end
        else
        begin
            tick_reg     <= tick_next;
            bit_cnt_reg  <= bit_cnt_next;
            shift_reg    <= shift_next;
            byte_idx_reg <= byte_idx_next;
            addr_reg     <= addr_next;
            dir_reg      <= dir_next;
            count_reg    <= count_next;
            fill_reg     <= fill_next;
            nack_reg     <= nack_next;
            line_scl_reg <= line_scl_next;
            line_sda_reg <= line_sda_next;
            if (cfg_wr)
            begin
                dev_addr_reg <= cfg_data;
            end
        end
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res_d.done_res) |=> (phase_reg == PH_IDLE && fill_reg == '0))
        else $error("stop did not return to idle with an empty buffer");

    a_read_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res_d.read_valid) |-> (dir_reg && phase_reg == PH_RBIT))
        else $error("read byte delivered outside a read transfer");

    a_cmd_lines: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.cmd != CMD_TICK) |=> ($stable(line_scl_reg) && $stable(line_sda_reg)))
        else $error("command beat changed the driven bus levels");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we) |=> (fill_reg == $past(fill_reg) + 1'b1 && phase_reg == PH_IDLE))
        else $error("buffer load while a transfer is open");

endmodule

// ----- src/i2c_register_access_master.sv -----
// top level of the i2c register access master
// Each accepted item is one bus interval (a tick) or a command; every item yields exactly one
// result, in order. The block takes one item per clock cycle and returns one result per cycle
// while the result queue has room; an item is registered in the input queue, handled by the
// combinational step of the bus sequencer and registered in the result queue. Write data is
// loaded into a MAX_BYTES-entry buffer ram before a start command; it needs no clearing pass.
// The device address register may be written only while no item or result is in flight.
module i2c_register_access_master #(
    parameter int MAX_BYTES = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [i2cram_pkg::FUNC_W-1:0]      func,
    input  logic                               sda_in,
    input  logic                               is_read,
    input  logic [i2cram_pkg::REG_ADDR_W-1:0]  reg_address,
    input  logic [i2cram_pkg::COUNT_W-1:0]     byte_count,
    input  logic [i2cram_pkg::BYTE_W-1:0]      write_byte,
    output logic                               empty,
    input  logic                               pop,
    output logic                               scl,
    output logic                               sda_out,
    output logic [i2cram_pkg::BYTE_W-1:0]      read_byte,
    output logic                               read_valid,
    output logic                               busy_res,
    output logic                               done_res,
    output logic                               nack_error,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [i2cram_pkg::DEV_ADDR_W-1:0]  cfg_data
);

    import i2cram_pkg::*;

    localparam int QUEUE_DEPTH = 2;

    logic    q_push;
    item_t   q_item;
    logic    in_full;
    item_t   in_head;
    logic    in_empty;
    logic    in_pop;
    logic    out_push;
    logic    out_full;
    result_t res_d;
    result_t res_q;

    assign cfg_ready = 1'b1;
    assign full      = in_full;

    i2cram_front #(
        .MAX_BYTES (MAX_BYTES)
    ) u_front (
        .push        (push),
        .q_full      (in_full),
        .func        (func),
        .sda_in      (sda_in),
        .is_read     (is_read),
        .reg_address (reg_address),
        .byte_count  (byte_count),
        .write_byte  (write_byte),
        .q_push      (q_push),
        .q_item      (q_item)
    );

    i2cram_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_in_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_item),
        .full    (in_full),
        .rd_en   (in_pop),
        .rd_data (in_head),
        .empty   (in_empty)
    );

    i2cram_back #(
        .MAX_BYTES (MAX_BYTES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .item     (in_head),
        .in_empty (in_empty),
        .in_pop   (in_pop),
        .out_full (out_full),
        .out_push (out_push),
        .res      (res_d)
    );

    i2cram_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_data (res_d),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (res_q),
        .empty   (empty)
    );

    assign scl        = res_q.scl;
    assign sda_out    = res_q.sda_out;
    assign read_byte  = res_q.read_byte;
    assign read_valid = res_q.read_valid;
    assign busy_res   = res_q.busy_res;
    assign done_res   = res_q.done_res;
    assign nack_error = res_q.nack_error;

endmodule

// ----- tb/tb.sv -----
// testbench for the i2c register access master: queue-side driver, bus predictor and checker
`timescale 1ns / 1ps

module tb;
    import i2cram_pkg::*;

    localparam int BUF_DEPTH = 16;

    typedef struct packed {
        logic [DEV_ADDR_W-1:0]          dev_addr;
        phase_t                         phase;
        logic [1:0]                     tick;
        logic [3:0]                     nbits;
        logic [BYTE_W-1:0]              shreg;
        logic [BIDX_W-1:0]              bidx;
        logic [REG_ADDR_W-1:0]          reg_addr;
        logic                           rd;
        logic [COUNT_W-1:0]             count;
        logic [BUF_DEPTH-1:0][BYTE_W-1:0] wbuf;
        logic [COUNT_W-1:0]             fill;
        logic [BUF_DEPTH-1:0]           loaded;
        logic                           nack;
        logic                           line_scl;
        logic                           line_sda;
    } bus_state_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic [FUNC_W-1:0] func = FUNC_TICK;
    logic sda_in = 1'b1;
    logic is_read = 1'b0;
    logic [REG_ADDR_W-1:0] reg_address = '0;
    logic [COUNT_W-1:0] byte_count = '0;
    logic [BYTE_W-1:0] write_byte = '0;
    logic empty;
    logic pop = 1'b0;
    logic scl;
    logic sda_out;
    logic [BYTE_W-1:0] read_byte;
    logic read_valid;
    logic busy_res;
    logic done_res;
    logic nack_error;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [DEV_ADDR_W-1:0] cfg_data = '0;

    item_t      bus_items[$];
    result_t    expected_bus_results[$];
    bus_state_t plan_state;
    bus_state_t bus_model;
    int tx_idle_pct = 14;
    int rx_idle_pct = 45;
    int phase_items = 0;
    int checked_results = 0;
    int mismatches = 0;
    logic rx_hold = 1'b0;
    logic hold_req = 1'b0;

    i2c_register_access_master u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .func        (func),
        .sda_in      (sda_in),
        .is_read     (is_read),
        .reg_address (reg_address),
        .byte_count  (byte_count),
        .write_byte  (write_byte),
        .empty       (empty),
        .pop         (pop),
        .scl         (scl),
        .sda_out     (sda_out),
        .read_byte   (read_byte),
        .read_valid  (read_valid),
        .busy_res    (busy_res),
        .done_res    (done_res),
        .nack_error  (nack_error),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic bus_state_t reset_state();
        bus_state_t s;
        s = '0;
        s.dev_addr = DEV_ADDR_RESET;
        s.phase = PH_IDLE;
        s.line_scl = 1'b1;
        s.line_sda = 1'b1;
        return s;
    endfunction

    function automatic logic [BYTE_W-1:0] header_byte(input bus_state_t s, input int idx);
        if (idx == 0)
            return {s.dev_addr, 1'b0};
        if (idx == 1)
            return s.reg_addr[15:8];
        if (idx == 2)
            return s.reg_addr[7:0];
        return {s.dev_addr, 1'b1};
    endfunction

    function automatic void next_byte(inout bus_state_t s, input logic [BYTE_W-1:0] value);
        s.shreg = value;
        s.nbits = '0;
        s.phase = PH_WBIT;
    endfunction

    // one item in, one bus interval (or command answer) out
    function automatic result_t bus_step(inout bus_state_t s, input item_t it);
        result_t r;
        logic busy;
        logic bit_done;
        logic done;
        int t;
        int k;
        r = '0;
        r.scl = s.line_scl;
        r.sda_out = s.line_sda;
        busy = (s.phase != PH_IDLE);
        bit_done = 1'b0;
        done = 1'b0;
        t = int'(s.tick);
        if (it.cmd == CMD_START && s.phase == PH_IDLE)
        begin
            s.rd = it.is_read;
            s.reg_addr = it.reg_address;
            s.count = (it.count > BUF_DEPTH) ? COUNT_W'(BUF_DEPTH) : it.count;
            s.bidx = '0;
            s.nack = 1'b0;
            s.tick = '0;
            s.phase = PH_START;
        end
        else if (it.cmd == CMD_LOAD && s.phase == PH_IDLE)
        begin
            if (s.fill < BUF_DEPTH)
            begin
                s.wbuf[s.fill] = it.write_byte;
                s.loaded[s.fill] = 1'b1;
                s.fill = s.fill + 1'b1;
            end
        end
        else if (it.cmd == CMD_TICK)
        begin
            case (s.phase)
                PH_START:
                begin
                    r.scl = (t < 2);
                    r.sda_out = (t == 0);
                    if (t >= 2)
                    begin
                        bit_done = 1'b1;
                        next_byte(s, header_byte(s, int'(s.bidx)));
                    end
                end
                PH_WBIT:
                begin
                    r.scl = (t >= 2);
                    r.sda_out = s.shreg[7];
                    if (t >= 2)
                    begin
                        bit_done = 1'b1;
                        s.shreg = s.shreg << 1;
                        s.nbits = s.nbits + 1'b1;
                        if (s.nbits >= 8)
                        begin
                            s.nbits = '0;
                            s.phase = PH_WACK;
                        end
                    end
                end
                PH_WACK:
                begin
                    r.scl = (t == 1);
                    r.sda_out = 1'b1;
                    if (t == 1)
                        s.nack = it.sda_in;
                    if (t >= 2)
                    begin
                        bit_done = 1'b1;
                        if (s.nack)
                            s.phase = PH_STOP;
                        else
                        begin
                            s.bidx = s.bidx + 1'b1;
                            k = int'(s.bidx);
                            if (k < HDR_BYTES)
                                next_byte(s, header_byte(s, k));
                            else if (!s.rd)
                            begin
                                if (k - HDR_BYTES < int'(s.count) && k - HDR_BYTES < BUF_DEPTH)
                                    next_byte(s, s.wbuf[k - HDR_BYTES]);
                                else
                                    s.phase = PH_STOP;
                            end
                            // read: repeated start, then the read address, then data
                            else if (k == HDR_BYTES)
                                s.phase = PH_START;
                            else if (s.count > 0)
                            begin
                                s.shreg = '0;
                                s.nbits = '0;
                                s.phase = PH_RBIT;
                            end
                            else
                                s.phase = PH_STOP;
                        end
                    end
                end
                PH_RBIT:
                begin
                    r.scl = (t >= 1);
                    r.sda_out = 1'b1;
                    if (t >= 1)
                    begin
                        bit_done = 1'b1;
                        s.shreg = {s.shreg[6:0], it.sda_in};
                        s.nbits = s.nbits + 1'b1;
                        if (s.nbits >= 8)
                        begin
                            r.read_valid = 1'b1;
                            r.read_byte = s.shreg;
                            s.nbits = '0;
                            s.phase = PH_RACK;
                        end
                    end
                end
                PH_RACK:
                begin
                    k = int'(s.bidx);
                    r.scl = (t == 1);
                    // nack only after the last data byte
                    r.sda_out = (k - HDR_BYTES >= int'(s.count));
                    if (t >= 2)
                    begin
                        bit_done = 1'b1;
                        s.bidx = s.bidx + 1'b1;
                        k = int'(s.bidx);
                        if (k - HDR_BYTES - 1 < int'(s.count))
                        begin
                            s.shreg = '0;
                            s.nbits = '0;
                            s.phase = PH_RBIT;
                        end
                        else
                            s.phase = PH_STOP;
                    end
                end
                PH_STOP:
                begin
                    r.scl = (t >= 1);
                    r.sda_out = (t >= 2);
                    if (t >= 2)
                    begin
                        bit_done = 1'b1;
                        done = 1'b1;
                        r.nack_error = s.nack;
                        s.nack = 1'b0;
                        s.fill = '0;
                        s.phase = PH_IDLE;
                    end
                end
                default:
                begin
                    s.phase = PH_IDLE;
                    r.scl = 1'b1;
                    r.sda_out = 1'b1;
                end
            endcase
            if (busy)
                s.tick = bit_done ? 2'd0 : s.tick + 2'd1;
            s.line_scl = r.scl;
            s.line_sda = r.sda_out;
        end
        if (it.cmd == CMD_TICK && s.phase == PH_IDLE && !done)
            busy = 1'b0;
        if (it.cmd != CMD_TICK)
            busy = (s.phase != PH_IDLE);
        r.busy_res = busy;
        r.done_res = done;
        return r;
    endfunction

    function automatic item_t random_item(input cmd_kind_t c);
        item_t it;
        it.cmd = c;
        it.sda_in = 1'($urandom_range(0, 1));
        it.is_read = 1'($urandom_range(0, 1));
        it.reg_address = REG_ADDR_W'($urandom);
        it.count = COUNT_W'($urandom);
        it.write_byte = BYTE_W'($urandom);
        return it;
    endfunction

    function automatic cmd_kind_t any_command();
        int r;
        r = $urandom_range(0, 2);
        return (r == 0) ? CMD_START : (r == 1) ? CMD_LOAD : CMD_NOP;
    endfunction

    task automatic queue_item(input item_t it);
        bus_items.push_back(it);
        void'(bus_step(plan_state, it));
        phase_items++;
    endtask

    task automatic wait_drained();
        while (bus_items.size() != 0 || expected_bus_results.size() != 0)
            @(posedge clk);
    endtask

    // loads, start command, then ticks until the stop; nack_at picks which ack check fails
    task automatic send_transaction(input logic rd, input logic [REG_ADDR_W-1:0] addr,
                                    input int want, input int nload, input int nack_at,
                                    input int noise_pct);
        item_t it;
        int i;
        int lead;
        int acks;
        for (i = 0; i < nload; i++)
        begin
            queue_item(random_item(CMD_LOAD));
            if ($urandom_range(0, 9) == 0)
                queue_item(random_item($urandom_range(0, 1) ? CMD_TICK : CMD_NOP));
        end
        // never let a write reach a buffer entry that was never loaded
        if (!rd)
        begin
            lead = 0;
            while (lead < BUF_DEPTH && plan_state.loaded[lead])
                lead++;
            if (lead < BUF_DEPTH && want > lead)
                want = lead;
        end
        it = random_item(CMD_START);
        it.is_read = rd;
        it.reg_address = addr;
        it.count = COUNT_W'(want);
        queue_item(it);
        acks = 0;
        while (plan_state.phase != PH_IDLE)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                queue_item(random_item(any_command()));
            it = random_item(CMD_TICK);
            if (plan_state.phase == PH_WACK && plan_state.tick == 1)
            begin
                it.sda_in = (acks == nack_at);
                acks++;
            end
            queue_item(it);
        end
    endtask

    task automatic random_phase(input int budget, input logic pause_midway);
        int r;
        int want;
        int nload;
        int nack_at;
        logic rd;
        phase_items = 0;
        while (phase_items < budget)
        begin
            r = $urandom_range(0, 99);
            want = (r < 78) ? $urandom_range(0, 3) :
                   (r < 96) ? $urandom_range(4, 8) : $urandom_range(16, 31);
            rd = 1'($urandom_range(0, 1));
            r = $urandom_range(0, 99);
            if (rd)
                nload = $urandom_range(0, 2);
            else if (r < 70)
                nload = (want > BUF_DEPTH) ? BUF_DEPTH : want;
            else if (r < 85)
                nload = 0;
            else
                nload = $urandom_range(0, 20);
            nack_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 5) : -1;
            send_transaction(rd, REG_ADDR_W'($urandom), want, nload, nack_at, 4);
            repeat ($urandom_range(0, 3))
                queue_item(random_item(CMD_TICK));
            if ($urandom_range(0, 4) == 0)
                queue_item(random_item(CMD_NOP));
            if (pause_midway && phase_items >= budget / 2)
            begin
                wait_drained();
                pause_midway = 1'b0;
            end
        end
    endtask

    task automatic set_dev_addr(input logic [DEV_ADDR_W-1:0] value);
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        plan_state.dev_addr = value;
        bus_model.dev_addr = value;
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatches < 40)
            $display("mismatch on %s at result %0d: got %h, expected %h",
                     what, checked_results, got, want);
        mismatches++;
    endtask

    // driver: offer the oldest pending item, predict it once taken
    always @(posedge clk)
    begin : drive
        item_t taken;
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
            begin
                taken = bus_items.pop_front();
                expected_bus_results.push_back(bus_step(bus_model, taken));
            end
            if (!(push && full))
            begin
                if (bus_items.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    push <= 1'b1;
                    func <= bus_items[0].cmd;
                    sda_in <= bus_items[0].sda_in;
                    is_read <= bus_items[0].is_read;
                    reg_address <= bus_items[0].reg_address;
                    byte_count <= bus_items[0].count;
                    write_byte <= bus_items[0].write_byte;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // monitor: every popped beat against the oldest expectation
    always @(posedge clk)
    begin : watch
        result_t want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (expected_bus_results.size() == 0)
                    report_mismatch("unexpected beat", 8'h00, 8'h00);
                else
                begin
                    want = expected_bus_results.pop_front();
                    if (scl !== want.scl)
                        report_mismatch("scl", 8'(scl), 8'(want.scl));
                    if (sda_out !== want.sda_out)
                        report_mismatch("sda_out", 8'(sda_out), 8'(want.sda_out));
                    if (read_byte !== want.read_byte)
                        report_mismatch("read_byte", read_byte, want.read_byte);
                    if (read_valid !== want.read_valid)
                        report_mismatch("read_valid", 8'(read_valid), 8'(want.read_valid));
                    if (busy_res !== want.busy_res)
                        report_mismatch("busy_res", 8'(busy_res), 8'(want.busy_res));
                    if (done_res !== want.done_res)
                        report_mismatch("done_res", 8'(done_res), 8'(want.done_res));
                    if (nack_error !== want.nack_error)
                        report_mismatch("nack_error", 8'(nack_error), 8'(want.nack_error));
                end
                checked_results++;
            end
            pop <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // long receiver hold-off so the block backs up and stalls its input
    initial
    begin
        wait (hold_req);
        repeat (20) @(posedge clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        item_t it;
        plan_state = reset_state();
        bus_model = reset_state();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        queue_item(random_item(CMD_NOP));
        it = random_item(CMD_TICK);
        it.sda_in = 1'b0;
        queue_item(it);
        it.sda_in = 1'b1;
        queue_item(it);
        // zero-count write stops after the register address
        send_transaction(1'b0, 16'hFFFF, 0, 0, -1, 0);
        // too many loads fill the buffer; count above the maximum saturates
        send_transaction(1'b0, 16'h0000, 31, 18, -1, 0);
        // zero-count read stops after the read address
        send_transaction(1'b1, 16'h8001, 0, 1, -1, 0);
        // read with commands thrown in while busy
        send_transaction(1'b1, 16'h7FFE, 2, 0, -1, 10);
        // count above fill resends bytes left from the earlier write
        send_transaction(1'b0, 16'h1234, 3, 1, -1, 0);
        send_transaction(1'b0, 16'h00FF, 1, 1, 0, 0);
        send_transaction(1'b1, 16'hFF00, 1, 0, 3, 0);
        send_transaction(1'b0, 16'h5A5A, 2, 2, 3, 0);

        set_dev_addr(7'h7F);
        hold_req = 1'b1;
        random_phase(60, 1'b0);

        set_dev_addr(7'h00);
        tx_idle_pct = 45;
        rx_idle_pct = 14;
        random_phase(60, 1'b1);

        set_dev_addr(DEV_ADDR_W'($urandom_range(1, 126)));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_phase(60, 1'b0);

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
